FILE: rtl/imuoc_pkg.sv
// ----------------------------------------------------------------------------
// IMU offset calibrator package
// Field widths, operation and status codes shared by the calibrator RTL.
// ----------------------------------------------------------------------------
package imuoc_pkg;

	localparam int AXES    = 6;
	localparam int AXIS_W  = 3;
	localparam int RAW_W   = 16;
	localparam int SUM_W   = 32;
	localparam int OFF_W   = 25;
	localparam int TOTAL_W = 16;
	localparam int GRAV_W  = 15;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	// Index of the z accelerometer axis, the one that carries gravity.
	localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = 3'd2;
	localparam logic [AXIS_W-1:0] AXIS_LAST    = 3'd5;

	localparam int RAW_MAX = 32767;
	localparam int RAW_MIN = -32768;

	localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_APPLY  = 2'd2;
	localparam logic [OP_W-1:0] OP_FAIL   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ZERO_CNT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_READ_FAIL = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_CALIB = 2'd3;

	typedef logic signed [RAW_W-1:0] raw_t;
	typedef logic signed [OFF_W-1:0] off_t;
	typedef logic [SUM_W-1:0]        sum_t;

endpackage

FILE: rtl/imu_offset_calibrator.sv
// ----------------------------------------------------------------------------
// IMU offset calibrator
// Averages raw six-axis samples into Q-format offsets and corrects samples.
// ----------------------------------------------------------------------------
// The block takes one beat at a time and drops s_tready until that beat's
// result has been placed in the output register. A begin, a read failure or a
// sample that arrives while no run is open goes straight to the post state,
// which loads its result into the output register once that register is
// free. An ordinary calibration sample or an apply beat first walks the six
// axes through a single adder or subtractor, one axis a cycle. The sample
// that completes a run then also divides all six sums by sample_total in one
// shared restoring divider that produces one quotient bit a cycle; for each
// axis it loads the dividend, steps through its bits and stores the offset.
// A finished result waits in the output register while the next beat is
// already being taken.
module imu_offset_calibrator
	import imuoc_pkg::*;
#(
	parameter int COUNT_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// s_tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32],
	//          gyro_x[63:48], gyro_y[79:64], gyro_z[95:80]
	input  logic [AXES*RAW_W-1:0]      s_tdata,
	// s_tuser: operation[1:0]
	input  logic [OP_W-1:0]            s_tuser,
	// Result stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// m_tdata: out_accel_x[24:0], out_accel_y[49:25], out_accel_z[74:50],
	//          out_gyro_x[99:75], out_gyro_y[124:100], out_gyro_z[149:125],
	//          zero padding[151:150]
	output logic [151:0]               m_tdata,
	// m_tuser: status[1:0], calib_done[2]
	output logic [2:0]                 m_tuser,
	// Register port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	// Dividend width: a 32-bit sum magnitude scaled by the fractional bits.
	localparam int NW   = SUM_W + FRAC_BITS;
	localparam int BCW  = $clog2(NW);
	// Signed quotient with room for the gravity subtraction.
	localparam int QW   = NW + 2;
	localparam int CMPW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
	// Apply path width: scaled raw value minus offset, plus a bit for negation.
	localparam int DW   = ((RAW_W + FRAC_BITS > OFF_W) ? RAW_W + FRAC_BITS : OFF_W) + 2;

	localparam logic signed [QW-1:0] Q_MAX = QW'((64'sd1 <<< (OFF_W - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);
	localparam logic signed [DW-1:0] D_MAX = DW'(RAW_MAX);
	localparam logic signed [DW-1:0] D_MIN = DW'(RAW_MIN);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_DLOAD = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_APPLY = 3'd5;
	localparam logic [2:0] ST_POST  = 3'd6;

	logic [2:0]            state_q;
	logic [AXIS_W-1:0]     axis_q;
	logic [BCW-1:0]        bit_q;
	raw_t                  raw_q [AXES];
	sum_t                  sums_q [AXES];
	off_t                  offs_q [AXES];
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  calib_q;
	logic                  neg_q;
	logic [TOTAL_W-1:0]    rem_q;
	logic [NW-1:0]         num_q;
	off_t                  val_q [AXES];
	logic [STAT_W-1:0]     status_q;
	logic                  done_q;
	logic                  m_tvalid_q;
	off_t                  m_val_q [AXES];
	logic [STAT_W-1:0]     m_status_q;
	logic                  m_done_q;
	logic [TOTAL_W-1:0]    sample_total_q;
	logic [GRAV_W-1:0]     gravity_q;

	logic                  in_fire;
	logic                  cfg_write;
	logic                  out_load;

	// Accumulate path.
	sum_t                  acc_sum;
	logic [COUNT_BITS-1:0] cnt_next;
	logic                  run_hit;

	// Divider load and step.
	sum_t                  sum_sel;
	logic                  sum_neg;
	sum_t                  sum_mag;
	logic [TOTAL_W:0]      div_shift;
	logic [TOTAL_W+1:0]    div_diff;
	logic                  div_ge;
	logic [TOTAL_W-1:0]    rem_next;

	// Divider finish.
	logic signed [QW-1:0]  q_signed;
	logic signed [QW-1:0]  q_grav;
	logic signed [QW-1:0]  q_clamp;

	// Apply path.
	logic signed [DW-1:0]  ap_diff;
	logic signed [DW-1:0]  ap_mag;
	logic signed [DW-1:0]  ap_trunc;
	logic signed [DW-1:0]  ap_res;
	logic signed [DW-1:0]  ap_sat;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign out_load  = (state_q == ST_POST) && (!m_tvalid_q || m_tready);

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'(gravity_q) : 32'(sample_total_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {m_done_q, m_status_q};
	assign m_tdata  = {2'b00, m_val_q[5], m_val_q[4], m_val_q[3],
		m_val_q[2], m_val_q[1], m_val_q[0]};

	always_comb begin
		acc_sum  = sums_q[axis_q] + SUM_W'(raw_q[axis_q]);
		cnt_next = cnt_q + 1'b1;
		run_hit  = (CMPW'(cnt_next) == CMPW'(sample_total_q)) && (sample_total_q != '0);

		sum_sel = sums_q[axis_q];
		sum_neg = sum_sel[SUM_W-1];
		sum_mag = sum_neg ? (SUM_W'(0) - sum_sel) : sum_sel;

		// One restoring step: bring down the next dividend bit.
		div_shift = {rem_q, num_q[NW-1]};
		div_diff  = {1'b0, div_shift} - {2'b00, sample_total_q};
		div_ge    = !div_diff[TOTAL_W+1];
		rem_next  = div_ge ? div_diff[TOTAL_W-1:0] : div_shift[TOTAL_W-1:0];

		q_signed = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		q_grav   = q_signed;
		if (axis_q == AXIS_ACCEL_Z) begin
			q_grav = q_signed - $signed(QW'(gravity_q) << FRAC_BITS);
		end
		if (q_grav > Q_MAX) begin
			q_clamp = Q_MAX;
		end else if (q_grav < Q_MIN) begin
			q_clamp = Q_MIN;
		end else begin
			q_clamp = q_grav;
		end

		// Subtract the offset, then drop the fraction rounding toward zero.
		ap_diff  = (DW'(raw_q[axis_q]) <<< FRAC_BITS) - DW'(offs_q[axis_q]);
		ap_mag   = ap_diff[DW-1] ? -ap_diff : ap_diff;
		ap_trunc = ap_mag >> FRAC_BITS;
		ap_res   = ap_diff[DW-1] ? -ap_trunc : ap_trunc;
		if (ap_res > D_MAX) begin
			ap_sat = D_MAX;
		end else if (ap_res < D_MIN) begin
			ap_sat = D_MIN;
		end else begin
			ap_sat = ap_res;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_total_q <= TOTAL_W'(64);
			gravity_q      <= GRAV_W'(16384);
		end else if (cfg_write) begin
			if (paddr[2]) begin
				gravity_q <= pwdata[GRAV_W-1:0];
			end else begin
				sample_total_q <= pwdata[TOTAL_W-1:0];
			end
		end
	end

	// Sequencer and calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			calib_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				sums_q[i] <= '0;
				offs_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						axis_q <= '0;
						unique case (s_tuser)
							OP_BEGIN: begin
								if (sample_total_q == '0) begin
									calib_q <= 1'b0;
								end else begin
									for (int i = 0; i < AXES; i++) begin
										sums_q[i] <= '0;
										offs_q[i] <= '0;
									end
									cnt_q   <= '0;
									calib_q <= 1'b1;
								end
								state_q <= ST_POST;
							end
							OP_SAMPLE: begin
								state_q <= calib_q ? ST_ACC : ST_POST;
							end
							OP_APPLY: begin
								state_q <= ST_APPLY;
							end
							OP_FAIL: begin
								calib_q <= 1'b0;
								state_q <= ST_POST;
							end
							default: begin
								state_q <= ST_POST;
							end
						endcase
					end
				end
				ST_ACC: begin
					sums_q[axis_q] <= acc_sum;
					if (axis_q == AXIS_LAST) begin
						cnt_q  <= cnt_next;
						axis_q <= '0;
						if (run_hit) begin
							calib_q <= 1'b0;
							state_q <= ST_DLOAD;
						end else begin
							state_q <= ST_POST;
						end
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_DLOAD: begin
					bit_q   <= BCW'(NW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					offs_q[axis_q] <= q_clamp[OFF_W-1:0];
					if (axis_q == AXIS_LAST) begin
						state_q <= ST_POST;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DLOAD;
					end
				end
				ST_APPLY: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= ST_POST;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_POST: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working payload: captured sample, divider datapath and result values.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < AXES; i++) begin
				raw_q[i] <= raw_t'(s_tdata[i*RAW_W +: RAW_W]);
				val_q[i] <= '0;
			end
			done_q <= 1'b0;
			case (s_tuser)
				OP_BEGIN:  status_q <= (sample_total_q == '0) ? STAT_ZERO_CNT : STAT_OK;
				OP_SAMPLE: status_q <= calib_q ? STAT_OK : STAT_NOT_CALIB;
				OP_FAIL:   status_q <= STAT_READ_FAIL;
				default:   status_q <= STAT_OK;
			endcase
		end
		if (state_q == ST_ACC && axis_q == AXIS_LAST && run_hit) begin
			done_q <= 1'b1;
		end
		if (state_q == ST_DLOAD) begin
			neg_q <= sum_neg;
			rem_q <= '0;
			num_q <= NW'(sum_mag) << FRAC_BITS;
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			num_q <= {num_q[NW-2:0], div_ge};
		end
		if (state_q == ST_FIN) begin
			val_q[axis_q] <= q_clamp[OFF_W-1:0];
		end
		if (state_q == ST_APPLY) begin
			val_q[axis_q] <= ap_sat[OFF_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= status_q;
			m_done_q   <= done_q;
			for (int i = 0; i < AXES; i++) begin
				m_val_q[i] <= val_q[i];
			end
		end
	end

	// The divider never starts a step with a remainder at or above the divisor.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < sample_total_q))
		else $error("divider remainder not below divisor");

	// A run is closed before its division begins.
	a_div_not_calibrating: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DLOAD || state_q == ST_DIV || state_q == ST_FIN) |-> !calib_q)
		else $error("division while calibration run still open");

	// Finished offsets are only ever reported with an ok status.
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && done_q) |-> (status_q == STAT_OK))
		else $error("calibration done reported with error status");

	// Loading the output register returns the sequencer to idle with a valid result.
	a_post_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == ST_IDLE) && m_tvalid_q)
		else $error("result load did not present a beat");

endmodule
